@@ rtl/core/tcw_pkg.sv @@
// Shared constants and types for the text console writer.
// No dependencies; imported by the sequencer, the top level and the testbench.
`default_nettype none

package tcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// blank cell: grey on black space
	localparam logic [15:0] BLANK_CELL   = 16'h0720;
	localparam logic [7:0]  CH_NEWLINE   = 8'd10;
	localparam logic [7:0]  CH_BACKSPACE = 8'd8;
	localparam logic [7:0]  CH_SPACE     = 8'h20;

	// command codes
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_ERASE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_WRITE = 2'd3;

	// result request from the sequencer to the output registers
	typedef struct packed {
		logic       emit;
		logic       rd_hit;
		logic [6:0] col;
		logic [4:0] row;
	} tcw_result_t;

endpackage

`default_nettype wire

@@ rtl/core/tcw_ram.sv @@
// Screen cell memory: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module tcw_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write a beat
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tcw_ctrl.sv @@
// Command sequencer: cursor, put-character logic, scroll copy and clear sweeps.
// Depends on tcw_pkg; drives the ports of tcw_ram.
`default_nettype none

module tcw_ctrl #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = $clog2(COLUMNS * ROWS)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           command,
	input  wire logic [7:0]           char_code,
	input  wire logic [7:0]           attribute,
	input  wire logic [10:0]          cell_index,
	output logic                      ram_we,
	output logic      [AW-1:0]        ram_waddr,
	output logic      [15:0]          ram_wdata,
	output logic                      ram_re,
	output logic      [AW-1:0]        ram_raddr,
	input  wire logic [15:0]          ram_rdata,
	output tcw_pkg::tcw_result_t      res
);
	import tcw_pkg::*;

	localparam int CELLS      = COLUMNS * ROWS;
	localparam int CLW        = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);
	localparam int COPY_LAST  = (ROWS - 2) * COLUMNS - 1;
	localparam int BLANK_FIRST = (ROWS - 2) * COLUMNS;
	localparam int BLANK_LAST = (ROWS - 1) * COLUMNS - 1;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_RDATA = 3'd3;
	localparam logic [2:0] ST_COPY  = 3'd4;
	localparam logic [2:0] ST_BLANK = 3'd5;
	localparam logic [2:0] ST_CLEAR = 3'd6;

	logic [2:0]     state_q, state_d;
	logic [AW-1:0]  scan_q, scan_d;
	logic [CLW-1:0] col_q, col_d;
	logic [RW-1:0]  row_q, row_d;
	logic           pend_s1;
	logic [AW-1:0]  waddr_s1;

	logic [1:0]  cmd_q;
	logic [7:0]  ch_q;
	logic [7:0]  attr_q;
	logic [10:0] idx_q;

	logic           idx_ok;
	logic [CLW-1:0] col_eff;
	logic [RW-1:0]  row_eff;
	logic [CLW:0]   col_inc;
	logic [RW:0]    row_inc;
	logic           copy_beat;

	assign busy    = (state_q != ST_IDLE);
	assign idx_ok  = (32'(idx_q) < CELLS);
	assign col_eff = (32'(col_q) >= COLUMNS) ? '0 : col_q;
	assign row_eff = (32'(row_q) >= ROWS - 1) ? RW'(ROWS - 2) : row_q;
	assign col_inc = {1'b0, col_eff} + {{CLW{1'b0}}, 1'b1};
	assign row_inc = {1'b0, row_eff} + {{RW{1'b0}}, 1'b1};
	assign copy_beat = (state_q == ST_COPY);

	// latch the command beat
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q  <= command;
			ch_q   <= char_code;
			attr_q <= attribute;
			idx_q  <= cell_index;
		end
	end

	// next state, cursor, memory ports and result request
	always_comb begin
		state_d   = state_q;
		scan_d    = scan_q;
		col_d     = col_q;
		row_d     = row_q;
		ram_we    = 1'b0;
		ram_waddr = scan_q;
		ram_wdata = BLANK_CELL;
		ram_re    = 1'b0;
		ram_raddr = AW'(idx_q);
		res       = '0;

		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we = 1'b1;
				if (32'(scan_q) == CELLS - 1) begin
					scan_d   = '0;
					state_d  = ST_IDLE;
					res.emit = (state_q == ST_CLEAR);
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d  = ST_IDLE;
				res.emit = 1'b1;
				unique case (cmd_q)
					CMD_PUT: begin
						row_d = row_eff;
						if (ch_q == CH_NEWLINE) begin
							col_d = '0;
							row_d = row_inc[RW-1:0];
						end else if (ch_q == CH_BACKSPACE) begin
							col_d = col_eff;
							if (col_eff != '0) begin
								col_d     = col_eff - 1'b1;
								ram_we    = 1'b1;
								ram_waddr = AW'(32'(row_eff) * COLUMNS + 32'(col_d));
								ram_wdata = {attr_q, CH_SPACE};
							end
						end else begin
							ram_we    = 1'b1;
							ram_waddr = AW'(32'(row_eff) * COLUMNS + 32'(col_eff));
							ram_wdata = {attr_q, ch_q};
							if (32'(col_inc) == COLUMNS) begin
								col_d = '0;
								row_d = row_inc[RW-1:0];
							end else begin
								col_d = col_inc[CLW-1:0];
							end
						end
						// entering the status row scrolls the text area
						if (ch_q != CH_BACKSPACE && 32'(row_d) >= ROWS - 1) begin
							row_d    = RW'(ROWS - 2);
							scan_d   = '0;
							state_d  = ST_COPY;
							res.emit = 1'b0;
						end
					end
					CMD_ERASE: begin
						col_d    = '0;
						row_d    = '0;
						scan_d   = '0;
						state_d  = ST_CLEAR;
						res.emit = 1'b0;
					end
					CMD_READ: begin
						ram_re   = 1'b1;
						state_d  = ST_RDATA;
						res.emit = 1'b0;
					end
					CMD_WRITE: begin
						ram_we    = idx_ok;
						ram_waddr = AW'(idx_q);
						ram_wdata = {attr_q, ch_q};
					end
					default: begin
						res.emit = 1'b1;
					end
				endcase
			end
			ST_RDATA: begin
				state_d    = ST_IDLE;
				res.emit   = 1'b1;
				res.rd_hit = idx_ok;
			end
			ST_COPY: begin
				ram_re    = 1'b1;
				ram_raddr = scan_q + AW'(COLUMNS);
				if (32'(scan_q) == COPY_LAST) begin
					scan_d  = AW'(BLANK_FIRST);
					state_d = ST_BLANK;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			ST_BLANK: begin
				// the last copy beat takes the write port first
				if (!pend_s1) begin
					ram_we = 1'b1;
					if (32'(scan_q) == BLANK_LAST) begin
						scan_d   = '0;
						state_d  = ST_IDLE;
						res.emit = 1'b1;
					end else begin
						scan_d = scan_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase

		// copy beats write in the cycle after their reads
		if (pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = ram_rdata;
		end

		res.col = 7'(col_d);
		res.row = 5'(row_d);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			scan_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			col_q   <= col_d;
			row_q   <= row_d;
			pend_s1 <= copy_beat;
		end
	end

	// destination of the copy beat in flight
	always_ff @(posedge clk) begin
		waddr_s1 <= scan_q;
	end

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// Text console writer: screen memory, command sequencer and result registers.
// Put character and write cell pass through the execute state; read cell adds a read
// data state; a scroll walks the text area through the one memory port pair, copying
// the rows up and then blanking the last text row, and clear sweeps every cell. A new
// command is taken only while busy is low, after the previous one has left its states.
// After reset busy stays high while the memory is blanked.
`default_nettype none

module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  attribute,
	input  wire logic [10:0] cell_index,
	output logic             done,
	output logic      [6:0]  cursor_column,
	output logic      [4:0]  cursor_line,
	output logic      [15:0] cell_value
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;
	tcw_result_t   res;

	logic        done_q;
	logic [6:0]  col_q;
	logic [4:0]  row_q;
	logic [15:0] value_q;

	tcw_ram #(
		.DEPTH (CELLS),
		.AW    (AW),
		.DW    (16)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.AW      (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.char_code  (char_code),
		.attribute  (attribute),
		.cell_index (cell_index),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.res        (res)
	);

	// strobe a result beat for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.emit;
		end
	end

	// capture the result payload
	always_ff @(posedge clk) begin
		if (res.emit) begin
			col_q   <= res.col;
			row_q   <= res.row;
			value_q <= res.rd_hit ? ram_rdata : 16'h0000;
		end
	end

	assign done          = done_q;
	assign cursor_column = col_q;
	assign cursor_line   = row_q;
	assign cell_value    = value_q;

endmodule

`default_nettype wire

@@ rtl/core/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to its top level.
// Depends on the top level text_console_writer for the bind.
`default_nettype none

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [6:0]  cursor_column,
	input wire logic [4:0]  cursor_line
);

	// an accepted command beat holds off the next one
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted command");

	// a result beat lasts one cycle and leaves the block idle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("done strobe longer than one cycle or while busy");

	// the cursor never rests in the status row or past the right edge
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(cursor_column) < COLUMNS)
			&& (ROWS > 32 || 32'(cursor_line) < ROWS - 1))
		else $error("cursor out of the text area");

	// the blanking pass after reset keeps the block busy
	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> busy && !done)
		else $error("block idle right after reset");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.cursor_column (cursor_column),
	.cursor_line   (cursor_line)
);

`default_nettype wire

@@ test/tb_text_console_writer.sv @@
// Self-checking testbench for text_console_writer: mirrors the screen and cursor,
// drives commands in random bursts and compares every done beat with the mirror.
// Depends on tcw_pkg and the text_console_writer RTL only.
`default_nettype none

module tb_text_console_writer;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int COLUMNS    = COLUMNS_DEF;
	localparam int ROWS       = ROWS_DEF;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int RANDOM_ITEMS = 1000;

	// cursor and cell value reported by one done beat
	typedef struct packed {
		logic [6:0]  col;
		logic [4:0]  row;
		logic [15:0] value;
	} cursor_report_t;

	// mirror of the screen memory and cursor, with the reports it predicts
	class screen_mirror;
		logic [15:0]    cells [CELL_COUNT];
		logic [6:0]     col;
		logic [4:0]     row;
		cursor_report_t pending_reports [$];
		int             mismatches;

		function new();
			mismatches = 0;
			blank_screen();
		endfunction

		function void blank_screen();
			for (int i = 0; i < CELL_COUNT; i++)
				cells[i] = BLANK_CELL;
			col = '0;
			row = '0;
		endfunction

		function int outstanding();
			return pending_reports.size();
		endfunction

		// apply one accepted command and queue the report it causes
		function void apply_command(logic [1:0] cmd, logic [7:0] ch, logic [7:0] attr,
				logic [10:0] idx);
			cursor_report_t rpt;
			logic [15:0]    value;
			value = '0;
			case (cmd)
				CMD_PUT: begin
					if (row >= ROWS - 1)
						row = 5'(ROWS - 2);
					if (col >= COLUMNS)
						col = '0;
					if (ch == CH_BACKSPACE) begin
						// step back and blank, no wrap or scroll
						if (col > 0) begin
							col = col - 7'd1;
							cells[row * COLUMNS + col] = {attr, CH_SPACE};
						end
					end else begin
						if (ch == CH_NEWLINE) begin
							col = '0;
							row = row + 5'd1;
						end else begin
							cells[row * COLUMNS + col] = {attr, ch};
							col = col + 7'd1;
						end
						if (col >= COLUMNS) begin
							col = '0;
							row = row + 5'd1;
						end
						// scroll the text area, leave the status row alone
						if (row >= ROWS - 1) begin
							for (int i = 0; i < (ROWS - 2) * COLUMNS; i++)
								cells[i] = cells[i + COLUMNS];
							for (int i = (ROWS - 2) * COLUMNS; i < (ROWS - 1) * COLUMNS; i++)
								cells[i] = BLANK_CELL;
							row = 5'(ROWS - 2);
						end
					end
				end
				CMD_ERASE: begin
					blank_screen();
				end
				CMD_READ: begin
					if (idx < CELL_COUNT)
						value = cells[idx];
				end
				default: begin
					if (idx < CELL_COUNT)
						cells[idx] = {attr, ch};
				end
			endcase
			rpt.col   = col;
			rpt.row   = row;
			rpt.value = value;
			pending_reports.push_back(rpt);
		endfunction

		// compare one done beat with the oldest predicted report
		function void compare_report(logic [6:0] col_seen, logic [4:0] row_seen,
				logic [15:0] value_seen);
			cursor_report_t rpt;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: done beat with no command waiting (col %0d row %0d cell %h)",
						col_seen, row_seen, value_seen);
				return;
			end
			rpt = pending_reports.pop_front();
			if (col_seen !== rpt.col || row_seen !== rpt.row || value_seen !== rpt.value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected col %0d row %0d cell %h, got col %0d row %0d cell %h",
						rpt.col, rpt.row, rpt.value, col_seen, row_seen, value_seen);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  command = CMD_PUT;
	logic [7:0]  char_code = '0;
	logic [7:0]  attribute = '0;
	logic [10:0] cell_index = '0;
	wire logic        busy;
	wire logic        done;
	wire logic [6:0]  cursor_column;
	wire logic [4:0]  cursor_line;
	wire logic [15:0] cell_value;

	screen_mirror mirror = new();
	int burst_left = 1;
	int random_items = 0;

	text_console_writer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.char_code     (char_code),
		.attribute     (attribute),
		.cell_index    (cell_index),
		.done          (done),
		.cursor_column (cursor_column),
		.cursor_line   (cursor_line),
		.cell_value    (cell_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#40ms;
		$display("end of test: mismatches");
		$finish;
	end

	// watch both handshakes on the edge that completes them
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.compare_report(cursor_column, cursor_line, cell_value);
			if (start && !busy)
				mirror.apply_command(command, char_code, attribute, cell_index);
		end
	end

	// offer one command beat, hold it until taken, then idle between bursts
	task automatic send_beat(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [7:0] attr, input logic [10:0] idx);
		int gap;
		start      <= 1'b1;
		command    <= cmd;
		char_code  <= ch;
		attribute  <= attr;
		cell_index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	// drop start and hold off until every predicted report has come back
	task automatic wait_for_reports();
		start <= 1'b0;
		do
			@(posedge clk);
		while (mirror.outstanding() != 0);
	endtask

	// random part: episodes of typed text, newline runs, reads, writes and clears
	task automatic run_random();
		int          kind;
		int          n;
		int          pick;
		logic [7:0]  ch;
		logic [10:0] idx;
		while (random_items < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// a line of text with the odd backspace or newline inside
				n = $urandom_range(1, 100);
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(0, 99);
					if (pick < 8)
						ch = CH_BACKSPACE;
					else if (pick < 10)
						ch = CH_NEWLINE;
					else
						ch = 8'($urandom_range(0, 255));
					send_beat(CMD_PUT, ch, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
				end
				random_items += n;
				if ($urandom_range(0, 1) == 0) begin
					send_beat(CMD_PUT, CH_NEWLINE, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
					random_items++;
				end
			end else if (kind < 55) begin
				// newlines that reach the bottom and scroll
				n = $urandom_range(1, 30);
				for (int i = 0; i < n; i++)
					send_beat(CMD_PUT, CH_NEWLINE, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
				random_items += n;
			end else if (kind < 80) begin
				// read back cells, half of them in the cursor row
				n = $urandom_range(1, 16);
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(0, 9);
					if (pick < 5)
						idx = 11'(32'(mirror.row) * COLUMNS + $urandom_range(0, COLUMNS - 1));
					else if (pick < 9)
						idx = 11'($urandom_range(0, CELL_COUNT - 1));
					else
						idx = 11'($urandom_range(CELL_COUNT, 2047));
					send_beat(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						idx);
				end
				random_items += n;
			end else if (kind < 95) begin
				// direct writes, mostly into the status row
				n = $urandom_range(1, 16);
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(0, 19);
					if (pick < 12)
						idx = 11'($urandom_range((ROWS - 1) * COLUMNS, CELL_COUNT - 1));
					else if (pick < 17)
						idx = 11'($urandom_range(0, CELL_COUNT - 1));
					else
						idx = 11'($urandom_range(CELL_COUNT, 2047));
					send_beat(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						idx);
				end
				random_items += n;
			end else if (kind < 98) begin
				send_beat(CMD_ERASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					11'($urandom_range(0, 2047)));
				random_items++;
			end else begin
				wait_for_reports();
			end
		end
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed: blank read, backspace at the left edge, extreme bytes, backspace
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd0);
		send_beat(CMD_PUT,   CH_BACKSPACE, 8'hFF, 11'd0);
		send_beat(CMD_PUT,   8'h41, 8'h00, 11'd0);
		send_beat(CMD_PUT,   8'hFF, 8'hFF, 11'd2047);
		send_beat(CMD_PUT,   8'h00, 8'h1E, 11'd0);
		send_beat(CMD_PUT,   8'h80, 8'h70, 11'd0);
		send_beat(CMD_PUT,   CH_BACKSPACE, 8'hA5, 11'd0);
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd2);
		send_beat(CMD_READ,  8'hFF, 8'hFF, 11'd3);
		send_beat(CMD_PUT,   CH_NEWLINE, 8'h07, 11'd0);
		send_beat(CMD_PUT,   8'h7A, 8'h4F, 11'd0);
		// status row and out-of-range writes and reads
		send_beat(CMD_WRITE, 8'h55, 8'hAA, 11'd1999);
		send_beat(CMD_WRITE, 8'hAA, 8'h55, 11'd1920);
		send_beat(CMD_WRITE, 8'h12, 8'h34, 11'd2000);
		send_beat(CMD_WRITE, 8'hFF, 8'hFF, 11'd2047);
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd1999);
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd2000);
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd2047);
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd1920);
		// clear blanks the status row too
		send_beat(CMD_ERASE, 8'hFF, 8'hFF, 11'd2047);
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd1999);
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd80);
		send_beat(CMD_WRITE, 8'h00, 8'h00, 11'd0);
		send_beat(CMD_READ,  8'h00, 8'h00, 11'd0);
		wait_for_reports();

		run_random();

		// drain, then give a stray beat time to show up
		wait_for_reports();
		repeat (2100)
			@(posedge clk);
		if (mirror.mismatches == 0 && mirror.outstanding() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer.sv
rtl/core/tcw_checker.sv
test/tb_text_console_writer.sv
